// ===== rtl/frae_pkg.sv =====
`timescale 1ns / 1ps

package frae_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned MAP_W    = 64;
   localparam int unsigned FN_W     = 4;
   localparam int unsigned OUT_REGS = 4;
   localparam int unsigned Q_DEPTH  = 2;

   localparam logic [MAP_W-1:0] MAP_RESET = 64'hFEDC_BA98_7654_3210;

   // register indexes on the configuration port
   localparam logic CSR_OPCODE_MAP = 1'b0;

   typedef enum logic [FN_W-1:0] {
      FN_ADDR = 4'd0,
      FN_ADDI = 4'd1,
      FN_MULR = 4'd2,
      FN_MULI = 4'd3,
      FN_BANR = 4'd4,
      FN_BANI = 4'd5,
      FN_BORR = 4'd6,
      FN_BORI = 4'd7,
      FN_SETR = 4'd8,
      FN_SETI = 4'd9,
      FN_GTIR = 4'd10,
      FN_GTRI = 4'd11,
      FN_GTRR = 4'd12,
      FN_EQIR = 4'd13,
      FN_EQRI = 4'd14,
      FN_EQRR = 4'd15
   } fn_type;

   typedef struct packed {
      logic a_is_reg;
      logic b_is_reg;
   } kind_type;

   typedef struct packed {
      fn_type              fn;
      logic [DATA_W-1:0]   a;
      logic [DATA_W-1:0]   b;
      logic [1:0]          dest;
      logic                err;
   } dec_type;

   function automatic kind_type operand_kind(input fn_type fn);
      kind_type k;
      k = '{a_is_reg: 1'b1, b_is_reg: 1'b0};
      case (fn)
         FN_ADDR, FN_MULR, FN_BANR, FN_BORR, FN_GTRR, FN_EQRR: begin
            k = '{a_is_reg: 1'b1, b_is_reg: 1'b1};
         end
         FN_ADDI, FN_MULI, FN_BANI, FN_BORI, FN_SETR, FN_GTRI, FN_EQRI: begin
            k = '{a_is_reg: 1'b1, b_is_reg: 1'b0};
         end
         FN_SETI: begin
            k = '{a_is_reg: 1'b0, b_is_reg: 1'b0};
         end
         FN_GTIR, FN_EQIR: begin
            k = '{a_is_reg: 1'b0, b_is_reg: 1'b1};
         end
         default: begin
            k = '{a_is_reg: 1'b1, b_is_reg: 1'b1};
         end
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/frae_front.sv =====
`timescale 1ns / 1ps

module frae_front #(
   parameter int unsigned NUM_REGS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [3:0]                        req_op,
   input  logic signed [31:0]                req_operand_a,
   input  logic signed [31:0]                req_operand_b,
   input  logic [1:0]                        req_dest_index,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [3:0]                        csr_paddr,
   input  logic [frae_pkg::MAP_W-1:0]        csr_pwdata,
   output logic [frae_pkg::MAP_W-1:0]        csr_prdata,
   output logic                              csr_pready,
   output logic                              push_valid,
   input  logic                              push_stall,
   output frae_pkg::dec_type                 push_word
);

   localparam logic [frae_pkg::DATA_W-1:0] NREGS = frae_pkg::DATA_W'(NUM_REGS);

   logic [frae_pkg::MAP_W-1:0] map_ff, map_in;
   logic                        wr_en;
   logic [frae_pkg::FN_W-1:0]   fn_raw;
   frae_pkg::fn_type            fn;
   frae_pkg::kind_type          kind;
   logic                        a_bad, b_bad, d_bad;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready
                  && (csr_paddr[3] == frae_pkg::CSR_OPCODE_MAP);
   assign map_in = wr_en ? csr_pwdata : map_ff;
   assign csr_prdata = (csr_paddr[3] == frae_pkg::CSR_OPCODE_MAP) ? map_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= frae_pkg::MAP_RESET;
      end else begin
         map_ff <= map_in;
      end
   end

   // classify: map the opcode and check every register operand
   assign fn_raw = map_ff[{req_op, 2'b00} +: frae_pkg::FN_W];
   assign fn     = frae_pkg::fn_type'(fn_raw);
   assign kind   = frae_pkg::operand_kind(fn);
   assign a_bad  = kind.a_is_reg && (unsigned'(req_operand_a) >= NREGS);
   assign b_bad  = kind.b_is_reg && (unsigned'(req_operand_b) >= NREGS);
   assign d_bad  = {30'd0, req_dest_index} >= NREGS;

   assign req_stall       = push_stall;
   assign push_valid      = req_valid;
   assign push_word.fn    = fn;
   assign push_word.a     = unsigned'(req_operand_a);
   assign push_word.b     = unsigned'(req_operand_b);
   assign push_word.dest  = req_dest_index;
   assign push_word.err   = a_bad || b_bad || d_bad;

endmodule

// ===== rtl/frae_queue.sv =====
`timescale 1ns / 1ps

module frae_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  frae_pkg::dec_type in_word,
   output logic              out_valid,
   input  logic              out_stall,
   output frae_pkg::dec_type out_word
);

   localparam int unsigned PTR_W = $clog2(frae_pkg::Q_DEPTH);
   localparam int unsigned CNT_W = $clog2(frae_pkg::Q_DEPTH + 1);

   frae_pkg::dec_type   mem_ff [frae_pkg::Q_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                push, pop;

   assign in_stall  = (cnt_ff == CNT_W'(frae_pkg::Q_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   assign wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign cnt_in    = cnt_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_word;
      end
   end

endmodule

// ===== rtl/frae_back.sv =====
`timescale 1ns / 1ps

module frae_back #(
   parameter int unsigned NUM_REGS = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_stall,
   input  frae_pkg::dec_type        pop_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_reg_zero,
   output logic signed [31:0]       rsp_reg_one,
   output logic signed [31:0]       rsp_reg_two,
   output logic signed [31:0]       rsp_reg_three,
   output logic                     rsp_index_error
);

   localparam int unsigned IDX_W = $clog2(NUM_REGS);
   localparam int unsigned DW    = frae_pkg::DATA_W;

   logic [DW-1:0]    regs_ff [NUM_REGS];
   logic [DW-1:0]    outs [frae_pkg::OUT_REGS];
   logic             valid_ff, valid_in;
   logic             err_ff, err_in;
   logic             take;
   logic [IDX_W-1:0] a_idx, b_idx, d_idx;
   logic [DW-1:0]    ra, rb, a, b, res;

   assign pop_stall = valid_ff && rsp_stall;
   assign take      = pop_valid && !pop_stall;
   assign valid_in  = take || (valid_ff && rsp_stall);
   assign err_in    = take ? pop_word.err : err_ff;

   assign a     = pop_word.a;
   assign b     = pop_word.b;
   assign a_idx = a[IDX_W-1:0];
   assign b_idx = b[IDX_W-1:0];
   assign d_idx = IDX_W'(pop_word.dest);
   assign ra    = regs_ff[a_idx];
   assign rb    = regs_ff[b_idx];

   always_comb begin
      res = '0;
      case (pop_word.fn)
         frae_pkg::FN_ADDR: res = ra + rb;
         frae_pkg::FN_ADDI: res = ra + b;
         frae_pkg::FN_MULR: res = ra * rb;
         frae_pkg::FN_MULI: res = ra * b;
         frae_pkg::FN_BANR: res = ra & rb;
         frae_pkg::FN_BANI: res = ra & b;
         frae_pkg::FN_BORR: res = ra | rb;
         frae_pkg::FN_BORI: res = ra | b;
         frae_pkg::FN_SETR: res = ra;
         frae_pkg::FN_SETI: res = a;
         frae_pkg::FN_GTIR: res = DW'($signed(a) > $signed(rb));
         frae_pkg::FN_GTRI: res = DW'($signed(ra) > $signed(b));
         frae_pkg::FN_GTRR: res = DW'($signed(ra) > $signed(rb));
         frae_pkg::FN_EQIR: res = DW'(a == rb);
         frae_pkg::FN_EQRI: res = DW'(ra == b);
         frae_pkg::FN_EQRR: res = DW'(ra == rb);
         default:           res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         err_ff   <= err_in;
      end
   end

   // register file only moves when a fresh word enters the output slot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (take && !pop_word.err) begin
         regs_ff[d_idx] <= res;
      end
   end

   for (genvar j = 0; j < frae_pkg::OUT_REGS; j++) begin : g_out
      if (j < NUM_REGS) begin : g_have
         assign outs[j] = regs_ff[j];
      end else begin : g_absent
         assign outs[j] = '0;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_index_error = err_ff;
   assign rsp_reg_zero    = signed'(outs[0]);
   assign rsp_reg_one     = signed'(outs[1]);
   assign rsp_reg_two     = signed'(outs[2]);
   assign rsp_reg_three   = signed'(outs[3]);

endmodule

// ===== rtl/four_register_alu_executor_top.sv =====
`timescale 1ns / 1ps
// Register-machine executor: one instruction per request word on a file of
// NUM_REGS 32-bit registers, reporting registers 0 to 3 after every step.
// Request channel (req_*): raw opcode, two operands, destination index.
// The opcode is mapped through the 64-bit opcode map (byte address 0 on
// the csr port) to one of sixteen ALU functions before it is queued.
// Response channel (rsp_*): one word per request, in order, with the four
// register values and index_error set when a register operand or the
// destination was out of range (no write done then).
// A request is written into the queue, then executed into the registered
// response slot that drives the rsp_* outputs.
// Throughput: one word per cycle while the response is not stalled, held
// by the execute stage that reads and writes the register file.
// Reset clears the register file, loads the identity opcode map and empties
// both the two-word queue and the response slot.
// A stalled response holds; the queue then fills, and after two more words
// req_stall rises until the receiver takes the response.
// Write the opcode map only while no request is in flight.

module four_register_alu_executor_top #(
   parameter int unsigned NUM_REGS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [3:0]                  req_op,
   input  logic signed [31:0]          req_operand_a,
   input  logic signed [31:0]          req_operand_b,
   input  logic [1:0]                  req_dest_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [31:0]          rsp_reg_zero,
   output logic signed [31:0]          rsp_reg_one,
   output logic signed [31:0]          rsp_reg_two,
   output logic signed [31:0]          rsp_reg_three,
   output logic                        rsp_index_error,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [3:0]                  csr_paddr,
   input  logic [63:0]                 csr_pwdata,
   output logic [63:0]                 csr_prdata,
   output logic                        csr_pready
);

   logic              push_valid, push_stall;
   frae_pkg::dec_type push_word;
   logic              pop_valid, pop_stall;
   frae_pkg::dec_type pop_word;

   frae_front #(.NUM_REGS(NUM_REGS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .req_dest_index (req_dest_index),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .push_valid     (push_valid),
      .push_stall     (push_stall),
      .push_word      (push_word)
   );

   frae_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_stall  (push_stall),
      .in_word   (push_word),
      .out_valid (pop_valid),
      .out_stall (pop_stall),
      .out_word  (pop_word)
   );

   frae_back #(.NUM_REGS(NUM_REGS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_stall       (pop_stall),
      .pop_word        (pop_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reg_zero    (rsp_reg_zero),
      .rsp_reg_one     (rsp_reg_one),
      .rsp_reg_two     (rsp_reg_two),
      .rsp_reg_three   (rsp_reg_three),
      .rsp_index_error (rsp_index_error)
   );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_WORDS = 340;
   localparam int unsigned EXTREME_WORDS = 25;
   localparam logic [3:0] ADDR_OPCODE_MAP = {frae_pkg::CSR_OPCODE_MAP, 3'b000};
   localparam logic [3:0] ADDR_UNMAPPED = 4'h8;

   typedef struct packed {
      logic [3:0]  op;
      logic [31:0] a;
      logic [31:0] b;
      logic [1:0]  dest;
   } instr_type;

   typedef struct packed {
      logic [31:0] r0;
      logic [31:0] r1;
      logic [31:0] r2;
      logic [31:0] r3;
      logic        err;
   } snapshot_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_op = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic [1:0] req_dest_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_reg_zero;
   logic signed [31:0] rsp_reg_one;
   logic signed [31:0] rsp_reg_two;
   logic signed [31:0] rsp_reg_three;
   logic rsp_index_error;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   instr_type instr_q[$];
   snapshot_type snapshot_q[$];
   logic [31:0] arch_regs[4];
   logic [63:0] map_shadow;
   logic req_fire = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   four_register_alu_executor_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .req_dest_index(req_dest_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_reg_zero(rsp_reg_zero), .rsp_reg_one(rsp_reg_one),
      .rsp_reg_two(rsp_reg_two), .rsp_reg_three(rsp_reg_three),
      .rsp_index_error(rsp_index_error),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h, want %h", what, got, want);
      error_count++;
   endtask

   function automatic snapshot_type execute_instr(input instr_type it);
      frae_pkg::fn_type f;
      logic a_reg;
      logic b_reg;
      logic [31:0] ra;
      logic [31:0] rb;
      logic [31:0] val;
      snapshot_type s;
      f = frae_pkg::fn_type'(map_shadow[it.op*4 +: 4]);
      a_reg = 1'b1;
      b_reg = 1'b0;
      case (f)
         frae_pkg::FN_SETI: begin
            a_reg = 1'b0;
         end
         frae_pkg::FN_GTIR, frae_pkg::FN_EQIR: begin
            a_reg = 1'b0;
            b_reg = 1'b1;
         end
         frae_pkg::FN_ADDR, frae_pkg::FN_MULR, frae_pkg::FN_BANR, frae_pkg::FN_BORR,
         frae_pkg::FN_GTRR, frae_pkg::FN_EQRR: begin
            b_reg = 1'b1;
         end
         default: begin
         end
      endcase
      s.err = (a_reg && it.a > 32'd3) || (b_reg && it.b > 32'd3);
      if (!s.err) begin
         ra = a_reg ? arch_regs[it.a[1:0]] : '0;
         rb = b_reg ? arch_regs[it.b[1:0]] : '0;
         case (f)
            frae_pkg::FN_ADDR: val = ra + rb;
            frae_pkg::FN_ADDI: val = ra + it.b;
            frae_pkg::FN_MULR: val = ra * rb;
            frae_pkg::FN_MULI: val = ra * it.b;
            frae_pkg::FN_BANR: val = ra & rb;
            frae_pkg::FN_BANI: val = ra & it.b;
            frae_pkg::FN_BORR: val = ra | rb;
            frae_pkg::FN_BORI: val = ra | it.b;
            frae_pkg::FN_SETR: val = ra;
            frae_pkg::FN_SETI: val = it.a;
            frae_pkg::FN_GTIR: val = {31'd0, $signed(it.a) > $signed(rb)};
            frae_pkg::FN_GTRI: val = {31'd0, $signed(ra) > $signed(it.b)};
            frae_pkg::FN_GTRR: val = {31'd0, $signed(ra) > $signed(rb)};
            frae_pkg::FN_EQIR: val = {31'd0, it.a == rb};
            frae_pkg::FN_EQRI: val = {31'd0, ra == it.b};
            default: val = {31'd0, ra == rb};
         endcase
         arch_regs[it.dest] = val;
      end
      s.r0 = arch_regs[0];
      s.r1 = arch_regs[1];
      s.r2 = arch_regs[2];
      s.r3 = arch_regs[3];
      return s;
   endfunction

   function automatic logic [31:0] pick_operand();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 70) return 32'($urandom_range(3));
      if (sel < 78) return 32'($urandom_range(15));
      if (sel < 80) return 32'h7FFF_FFFF;
      if (sel < 82) return 32'h8000_0000;
      if (sel < 84) return 32'hFFFF_FFFF;
      return 32'($urandom);
   endfunction

   task automatic push_instr(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                             input logic [1:0] dest);
      instr_type it;
      it.op = op;
      it.a = a;
      it.b = b;
      it.dest = dest;
      instr_q = {instr_q, it};
   endtask

   task automatic push_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         push_instr(4'($urandom_range(15)), pick_operand(), pick_operand(),
                    2'($urandom_range(3)));
      end
   endtask

   task automatic drain();
      while (instr_q.size() != 0 || req_valid || snapshot_q.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_access(input logic wr, input logic [3:0] addr, input logic [63:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (wr && addr == ADDR_OPCODE_MAP) map_shadow = data;
      if (!wr && csr_prdata !== map_shadow) report("opcode_map readback", csr_prdata, map_shadow);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [63:0] shuffled_map();
      logic [3:0] fns[16];
      logic [3:0] tmp;
      logic [63:0] m;
      int unsigned j;
      for (int i = 0; i < 16; i++) fns[i] = 4'(i);
      for (int i = 15; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = fns[i];
         fns[i] = fns[j];
         fns[j] = tmp;
      end
      for (int i = 0; i < 16; i++) m[i*4 +: 4] = fns[i];
      return m;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (!req_valid || req_fire) begin
            if (instr_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_op <= instr_q[0].op;
               req_operand_a <= instr_q[0].a;
               req_operand_b <= instr_q[0].b;
               req_dest_index <= instr_q[0].dest;
               void'(instr_q.pop_front());
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      instr_type it;
      snapshot_type want;
      req_fire <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         it.op = req_op;
         it.a = req_operand_a;
         it.b = req_operand_b;
         it.dest = req_dest_index;
         snapshot_q = {snapshot_q, execute_instr(it)};
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (snapshot_q.size() == 0) begin
            report("unexpected word", {32'd0, rsp_reg_zero}, '0);
         end else begin
            want = snapshot_q.pop_front();
            if (rsp_reg_zero !== want.r0)
               report("reg_zero", {32'd0, rsp_reg_zero}, {32'd0, want.r0});
            if (rsp_reg_one !== want.r1)
               report("reg_one", {32'd0, rsp_reg_one}, {32'd0, want.r1});
            if (rsp_reg_two !== want.r2)
               report("reg_two", {32'd0, rsp_reg_two}, {32'd0, want.r2});
            if (rsp_reg_three !== want.r3)
               report("reg_three", {32'd0, rsp_reg_three}, {32'd0, want.r3});
            if (rsp_index_error !== want.err)
               report("index_error", {63'd0, rsp_index_error}, {63'd0, want.err});
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      map_shadow = frae_pkg::MAP_RESET;
      for (int i = 0; i < 4; i++) arch_regs[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_access(1'b0, ADDR_OPCODE_MAP, '0);
      push_instr(frae_pkg::FN_SETI, 32'h7FFF_FFFF, 32'd0, 2'd0);
      push_instr(frae_pkg::FN_SETI, 32'h8000_0000, 32'd0, 2'd1);
      push_instr(frae_pkg::FN_SETI, 32'hFFFF_FFFF, 32'd0, 2'd2);
      push_instr(frae_pkg::FN_ADDR, 32'd0, 32'd0, 2'd3);
      push_instr(frae_pkg::FN_ADDI, 32'd0, 32'd1, 2'd3);
      push_instr(frae_pkg::FN_MULR, 32'd0, 32'd2, 2'd3);
      push_instr(frae_pkg::FN_MULI, 32'd1, 32'hFFFF_FFFF, 2'd3);
      push_instr(frae_pkg::FN_BANR, 32'd0, 32'd2, 2'd3);
      push_instr(frae_pkg::FN_BANI, 32'd2, 32'h5A5A_5A5A, 2'd3);
      push_instr(frae_pkg::FN_BORR, 32'd0, 32'd1, 2'd3);
      push_instr(frae_pkg::FN_BORI, 32'd1, 32'h0001_2345, 2'd3);
      push_instr(frae_pkg::FN_SETR, 32'd2, 32'hDEAD_BEEF, 2'd3);
      push_instr(frae_pkg::FN_GTIR, 32'h7FFF_FFFF, 32'd1, 2'd3);
      push_instr(frae_pkg::FN_GTRI, 32'd1, 32'd0, 2'd3);
      push_instr(frae_pkg::FN_GTRR, 32'd0, 32'd1, 2'd3);
      push_instr(frae_pkg::FN_EQIR, 32'hFFFF_FFFF, 32'd2, 2'd3);
      push_instr(frae_pkg::FN_EQRI, 32'd0, 32'h7FFF_FFFF, 2'd3);
      push_instr(frae_pkg::FN_EQRR, 32'd3, 32'd3, 2'd3);
      push_instr(frae_pkg::FN_ADDR, 32'd4, 32'd0, 2'd1);
      push_instr(frae_pkg::FN_ADDR, 32'd0, 32'hFFFF_FFFF, 2'd1);
      push_instr(frae_pkg::FN_GTIR, 32'hFFFF_FFFB, 32'h8000_0000, 2'd2);
      push_instr(frae_pkg::FN_SETI, 32'hFFFF_0000, 32'h8000_0000, 2'd0);
      push_instr(frae_pkg::FN_MULI, 32'h7FFF_FFFF, 32'd2, 2'd0);
      push_instr(frae_pkg::FN_EQRI, 32'd3, 32'h8000_0000, 2'd2);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 73;
               recv_stall_pct = 0;
               csr_access(1'b1, ADDR_OPCODE_MAP, shuffled_map());
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 73;
               csr_access(1'b1, ADDR_OPCODE_MAP, '0);
               push_random(EXTREME_WORDS);
               drain();
               csr_access(1'b1, ADDR_OPCODE_MAP, '1);
               csr_access(1'b0, ADDR_OPCODE_MAP, '0);
               push_random(EXTREME_WORDS);
               drain();
               csr_access(1'b1, ADDR_OPCODE_MAP, {$urandom, $urandom});
            end
            default: begin
               send_idle_pct = 17;
               recv_stall_pct = 17;
               // ignored write: an unmapped register index leaves the map alone
               csr_access(1'b1, ADDR_UNMAPPED, {$urandom, $urandom});
               csr_access(1'b1, ADDR_OPCODE_MAP, shuffled_map());
            end
         endcase
         csr_access(1'b0, ADDR_OPCODE_MAP, '0);
         push_random(PHASE_WORDS);
         drain();
      end

      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
